>>> hw/rtl/hlp_pkg.sv
// shared types, constants and the sine table of the hough line peaks block
// no dependencies
`timescale 1ns / 1ps

package hlp_pkg;

  localparam int MAX_DIAG    = 724;
  localparam int ANGLE_STEPS = 90;
  localparam int MAX_LINES   = 16;
  localparam int ACC_ROWS    = 2 * MAX_DIAG + 2;
  localparam int ACC_DEPTH   = ACC_ROWS * ANGLE_STEPS;
  localparam int ADDR_W      = $clog2(ACC_DEPTH);
  localparam int ROW_W       = $clog2(ACC_ROWS);
  localparam int K_W         = $clog2(ANGLE_STEPS);
  localparam int CNT_W       = $clog2(MAX_LINES + 1);
  localparam int IDX_W       = $clog2(MAX_LINES);
  localparam int VOTE_W      = 16;
  localparam int DIAG_W      = 10;
  localparam int THETA_W     = 8;

  // register indexes
  localparam logic [1:0] CFG_EDGE_THR = 2'd0;
  localparam logic [1:0] CFG_VOTE_THR = 2'd1;
  localparam logic [1:0] CFG_MAX_LINES = 2'd2;
  localparam logic [1:0] CFG_DIAG_LEN = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } ram_req_t;

  typedef struct packed {
    logic [DIAG_W-1:0]  rho;
    logic [THETA_W-1:0] theta;
    logic [VOTE_W-1:0]  votes;
  } peak_t;

  typedef struct packed {
    logic  valid;
    peak_t peak;
  } cand_t;

  // round(32768*sin(d)) for even d in 0..90
  localparam logic [15:0] QSIN [46] = '{
    16'd0, 16'd1144, 16'd2286, 16'd3425, 16'd4560, 16'd5690, 16'd6813, 16'd7927,
    16'd9032, 16'd10126, 16'd11207, 16'd12275, 16'd13328, 16'd14365, 16'd15384,
    16'd16384, 16'd17364, 16'd18324, 16'd19261, 16'd20174, 16'd21063, 16'd21926,
    16'd22763, 16'd23571, 16'd24351, 16'd25102, 16'd25822, 16'd26510, 16'd27166,
    16'd27789, 16'd28378, 16'd28932, 16'd29452, 16'd29935, 16'd30382, 16'd30792,
    16'd31164, 16'd31499, 16'd31795, 16'd32052, 16'd32270, 16'd32449, 16'd32588,
    16'd32688, 16'd32748, 16'd32768
  };

endpackage

>>> hw/rtl/hlp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module hlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/hlp_vote.sv
// vote address generator: one accumulator address per angle step
// depends on hlp_pkg
`timescale 1ns / 1ps

module hlp_vote (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [8:0]                row_i,
  input  logic [8:0]                col_i,
  input  logic [hlp_pkg::DIAG_W-1:0] diag_i,
  output logic                      busy_o,
  output hlp_pkg::ram_req_t         req_o
);
  import hlp_pkg::*;

  logic              active_q, active_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [8:0]        row_q, col_q;
  logic [DIAG_W-1:0] diag_q;
  logic              v1_q;
  logic [K_W-1:0]    k1_q;
  logic signed [26:0] s_q, s_d;
  ram_req_t          req_q, req_d;

  logic [5:0]  sidx, cidx;
  logic        cneg;
  logic [24:0] ps, pc;
  logic [26:0] mag;
  logic [ROW_W-1:0] m;
  logic signed [12:0] rs;

  // angle step counter
  always_comb begin
    active_d = active_q;
    k_d      = k_q;
    if (start_i) begin
      active_d = 1'b1;
      k_d      = '0;
    end else if (active_q) begin
      if (k_q == K_W'(ANGLE_STEPS - 1)) begin
        active_d = 1'b0;
      end
      k_d = k_q + K_W'(1);
    end
  end

  // sin and cos by quarter-wave symmetry, then row*sin + col*cos
  always_comb begin
    sidx = (k_q <= K_W'(45)) ? 6'(k_q) : 6'(K_W'(ANGLE_STEPS) - k_q);
    cneg = (k_q > K_W'(45));
    cidx = cneg ? 6'(k_q - K_W'(45)) : 6'(K_W'(45) - k_q);
    ps   = 25'(row_q) * 25'(QSIN[sidx]);
    pc   = 25'(col_q) * 25'(QSIN[cidx]);
    s_d  = cneg ? $signed({2'b0, ps}) - $signed({2'b0, pc})
                : $signed({2'b0, ps}) + $signed({2'b0, pc});
  end

  // truncate toward zero, offset, range check and address
  always_comb begin
    mag = s_q[26] ? 27'(-s_q) : 27'(s_q);
    m   = mag[15+ROW_W-1:15];
    rs  = s_q[26] ? $signed({3'b0, diag_q}) - $signed({2'b0, m})
                  : $signed({3'b0, diag_q}) + $signed({2'b0, m});
    req_d.valid = v1_q && !rs[12] && (rs <= $signed({2'b0, diag_q, 1'b1}));
    req_d.addr  = ADDR_W'(rs[ROW_W-1:0]) * ADDR_W'(ANGLE_STEPS) + ADDR_W'(k1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
      v1_q     <= 1'b0;
      req_q    <= '0;
    end else begin
      active_q <= active_d;
      k_q      <= k_d;
      v1_q     <= active_q;
      req_q    <= req_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      row_q  <= row_i;
      col_q  <= col_i;
      diag_q <= diag_i;
    end
    k1_q <= k_q;
    s_q  <= s_d;
  end

  assign busy_o = active_q;
  assign req_o  = req_q;

endmodule

>>> hw/rtl/hlp_scan.sv
// peak scan over the accumulator, clears every entry behind the read
// depends on hlp_pkg
`timescale 1ns / 1ps

module hlp_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hlp_pkg::DIAG_W-1:0] diag_i,
  input  logic [hlp_pkg::DIAG_W-1:0] span_i,
  input  logic [hlp_pkg::VOTE_W-1:0] vote_thr_i,
  input  logic [hlp_pkg::VOTE_W-1:0] rdata_i,
  output hlp_pkg::ram_req_t          rd_o,
  output hlp_pkg::ram_req_t          clr_o,
  output hlp_pkg::cand_t             cand_o,
  output logic                       done_o
);
  import hlp_pkg::*;

  localparam int LINE_LEN = 2 * ANGLE_STEPS;

  logic              active_q;
  logic [ROW_W-1:0]  rr_q;
  logic [K_W-1:0]    k_q;
  logic [ADDR_W-1:0] addr_q;
  logic              last_rd;
  logic              p_valid_q, p_last_q;
  logic [ROW_W-1:0]  p_rr_q;
  logic [K_W-1:0]    p_k_q;
  logic [ADDR_W-1:0] p_addr_q;
  logic [VOTE_W-1:0] line_q [LINE_LEN];
  cand_t             cand_q, cand_d;
  logic              done_q;
  logic [VOTE_W-1:0] ctr, blw;

  // the sweep covers every row that may hold votes, so all of them get cleared
  assign last_rd = (rr_q == {span_i, 1'b1}) && (k_q == K_W'(ANGLE_STEPS - 1));

  // read sweep in row order, angle inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rr_q      <= '0;
      k_q       <= '0;
      addr_q    <= '0;
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      cand_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
        rr_q     <= '0;
        k_q      <= '0;
        addr_q   <= '0;
      end else if (active_q) begin
        addr_q <= addr_q + ADDR_W'(1);
        if (k_q == K_W'(ANGLE_STEPS - 1)) begin
          k_q  <= '0;
          rr_q <= rr_q + ROW_W'(1);
        end else begin
          k_q <= k_q + K_W'(1);
        end
        if (last_rd) begin
          active_q <= 1'b0;
        end
      end
      p_valid_q <= active_q;
      p_last_q  <= active_q && last_rd;
      cand_q    <= cand_d;
      done_q    <= p_valid_q && p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_rr_q   <= rr_q;
    p_k_q    <= k_q;
    p_addr_q <= addr_q;
  end

  // two rows of history: center cell one row back, lower cell two rows back
  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      line_q[0] <= rdata_i;
      for (int i = 1; i < LINE_LEN; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  // peak test on the center cell
  always_comb begin
    ctr = line_q[ANGLE_STEPS-1];
    blw = line_q[LINE_LEN-1];
    cand_d.valid = p_valid_q && (p_k_q != '0) &&
                   (p_rr_q > ({1'b0, diag_i} + ROW_W'(1))) &&
                   (p_rr_q <= {diag_i, 1'b1}) &&
                   (ctr > vote_thr_i) && (ctr >= blw) && (ctr >= rdata_i);
    cand_d.peak.rho   = DIAG_W'(p_rr_q - ROW_W'(1) - {1'b0, diag_i});
    cand_d.peak.theta = THETA_W'({p_k_q, 1'b0});
    cand_d.peak.votes = ctr;
  end

  assign rd_o.valid  = active_q;
  assign rd_o.addr   = addr_q;
  assign clr_o.valid = p_valid_q;
  assign clr_o.addr  = p_addr_q;
  assign cand_o      = cand_q;
  assign done_o      = done_q;

endmodule

>>> hw/rtl/hlp_best.sv
// sorted list of the best peaks, one insertion per cycle
// depends on hlp_pkg
`timescale 1ns / 1ps

module hlp_best (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  hlp_pkg::cand_t            cand_i,
  input  logic [hlp_pkg::CNT_W-1:0] limit_i,
  input  logic [hlp_pkg::IDX_W-1:0] rd_idx_i,
  output logic [hlp_pkg::CNT_W-1:0] count_o,
  output hlp_pkg::peak_t            rd_peak_o
);
  import hlp_pkg::*;

  peak_t            ent_q [MAX_LINES];
  logic [CNT_W-1:0] cnt_q;
  logic [MAX_LINES-1:0] ge;
  logic [CNT_W-1:0] pos;
  logic             ins;

  // insertion point: entries that stay ahead (ties keep scan order)
  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      ge[i] = (CNT_W'(i) < cnt_q) && (ent_q[i].votes >= cand_i.peak.votes);
    end
    pos = CNT_W'($countones(ge));
    ins = cand_i.valid && (pos < limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clear_i) begin
      cnt_q <= '0;
    end else if (ins && (cnt_q < limit_i)) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      for (int i = 0; i < MAX_LINES; i++) begin
        if (CNT_W'(i) == pos) begin
          ent_q[i] <= cand_i.peak;
        end else if (i > 0 && CNT_W'(i) > pos) begin
          ent_q[i] <= ent_q[i-1];
        end
      end
    end
  end

  assign count_o   = cnt_q;
  assign rd_peak_o = ent_q[rd_idx_i];

endmodule

>>> hw/rtl/hough_line_peaks_core.sv
// hough line peak detector top level: control, accumulator ram, result output
// depends on hlp_pkg, hlp_ram, hlp_vote, hlp_scan, hlp_best
// an edge pixel runs one accumulator read-modify-write per angle step;
// other pixels are accepted without voting; a last pixel adds a drain, a scan
// with one ram read per cell over rows 0..2*diag+1 (diag the largest one used
// since the previous scan) and one result beat per peak, or a single empty one.
// after reset a clearing pass zeroes every accumulator entry before the first pixel.
`timescale 1ns / 1ps

module hough_line_peaks_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_row[8:0], pixel_col[17:9], edge_value[25:18], zero pad
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_rho[9:0], line_theta[17:10], line_votes[33:18], zero pad
  output logic [39:0] m_axis_tdata,
  // found[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import hlp_pkg::*;

  state_e            state_q, state_d;
  logic [7:0]        edge_thr_q;
  logic [VOTE_W-1:0] vote_thr_q;
  logic [4:0]        max_lines_q;
  logic [DIAG_W-1:0] diag_q;
  logic [DIAG_W-1:0] deff;
  logic [DIAG_W-1:0] span_q;
  logic [DIAG_W-1:0] sweep;
  logic [CNT_W-1:0]  limit;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [1:0]        drain_q;
  logic              last_q;
  logic [CNT_W-1:0]  e_q;
  logic [CNT_W-1:0]  n_res;
  logic              in_acc, vote_go;
  logic              vote_start, scan_start, ld;
  logic              vbusy, sdone;
  ram_req_t          vreq, srd, sclr;
  cand_t             cand;
  logic [CNT_W-1:0]  bcnt;
  peak_t             bpeak;
  logic              wv_q;
  logic [ADDR_W-1:0] wa_q;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VOTE_W-1:0] ram_wdata, ram_rdata;
  logic              ov_q;
  logic [39:0]       od_q;
  logic              ou_q, ol_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_thr_q  <= 8'd150;
      vote_thr_q  <= 16'd40;
      max_lines_q <= 5'd10;
      diag_q      <= 10'd724;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EDGE_THR:  edge_thr_q  <= cfg_wdata_i[7:0];
        CFG_VOTE_THR:  vote_thr_q  <= cfg_wdata_i;
        CFG_MAX_LINES: max_lines_q <= cfg_wdata_i[4:0];
        CFG_DIAG_LEN:  diag_q      <= cfg_wdata_i[DIAG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective diagonal and line limit
  always_comb begin
    if (diag_q == '0) deff = DIAG_W'(1);
    else if (diag_q > DIAG_W'(MAX_DIAG)) deff = DIAG_W'(MAX_DIAG);
    else deff = diag_q;
    if (max_lines_q == '0) limit = CNT_W'(1);
    else if (CNT_W'(max_lines_q) > CNT_W'(MAX_LINES)) limit = CNT_W'(MAX_LINES);
    else limit = CNT_W'(max_lines_q);
  end

  // rows the scan has to sweep: largest diagonal that voted since the last scan, or the current one if larger
  assign sweep = (span_q > deff) ? span_q : deff;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign vote_go = s_axis_tdata[25:18] > edge_thr_q;
  assign n_res   = (bcnt == '0) ? CNT_W'(1) : bcnt;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == ADDR_W'(ACC_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (vote_go) state_d = ST_VOTE;
          else if (s_axis_tlast) state_d = ST_DRAIN;
        end
      end
      ST_VOTE:  if (!vbusy) state_d = last_q ? ST_DRAIN : ST_IDLE;
      ST_DRAIN: if (drain_q == 2'd3) state_d = ST_SCAN;
      ST_SCAN:  if (sdone) state_d = ST_EMIT;
      ST_EMIT:  if (e_q == n_res) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    vote_start    = (state_q == ST_IDLE) && in_acc && vote_go;
    scan_start    = (state_q == ST_DRAIN) && (drain_q == 2'd3);
    ld            = (state_q == ST_EMIT) && (!ov_q || m_axis_tready) && (e_q < n_res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      drain_q    <= '0;
      last_q     <= 1'b0;
      e_q        <= '0;
      wv_q       <= 1'b0;
      ov_q       <= 1'b0;
      span_q     <= DIAG_W'(1);
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      drain_q <= (state_q == ST_DRAIN) ? drain_q + 2'd1 : 2'd0;
      if (in_acc) last_q <= s_axis_tlast;
      if (scan_start) e_q <= '0;
      else if (ld) e_q <= e_q + CNT_W'(1);
      wv_q <= vreq.valid;
      if (ld) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (sdone) span_q <= DIAG_W'(1);
      else if (vote_start && (deff > span_q)) span_q <= deff;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    wa_q <= vreq.addr;
    if (ld) begin
      if (bcnt == '0) begin
        od_q <= '0;
        ou_q <= 1'b0;
      end else begin
        od_q <= {6'b0, bpeak.votes, bpeak.theta, bpeak.rho};
        ou_q <= 1'b1;
      end
      ol_q <= (e_q + CNT_W'(1) == n_res);
    end
  end

  // accumulator port selection
  always_comb begin
    ram_re    = vreq.valid || srd.valid;
    ram_raddr = srd.valid ? srd.addr : vreq.addr;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (wv_q) begin
      ram_we    = 1'b1;
      ram_waddr = wa_q;
      ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + VOTE_W'(1);
    end else begin
      ram_we    = sclr.valid;
      ram_waddr = sclr.addr;
      ram_wdata = '0;
    end
  end

  hlp_ram #(
    .WIDTH(VOTE_W),
    .DEPTH(ACC_DEPTH)
  ) u_acc (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hlp_vote u_vote (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(vote_start),
    .row_i  (s_axis_tdata[8:0]),
    .col_i  (s_axis_tdata[17:9]),
    .diag_i (deff),
    .busy_o (vbusy),
    .req_o  (vreq)
  );

  hlp_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .diag_i    (deff),
    .span_i    (sweep),
    .vote_thr_i(vote_thr_q),
    .rdata_i   (ram_rdata),
    .rd_o      (srd),
    .clr_o     (sclr),
    .cand_o    (cand),
    .done_o    (sdone)
  );

  hlp_best u_best (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (scan_start),
    .cand_i   (cand),
    .limit_i  (limit),
    .rd_idx_i (e_q[IDX_W-1:0]),
    .count_o  (bcnt),
    .rd_peak_o(bpeak)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

endmodule
